// File: rtl/core/bde_pkg.sv
package bde_pkg;

  // Fixed field widths of the ports.
  localparam int PIN_WIDTH     = 8;
  localparam int DELAY_WIDTH   = 16;
  localparam int CFG_IDX_WIDTH = 2;

  // Defaults of the top-level parameters.
  localparam int BUTTONS_DEFAULT     = 8;
  localparam int COUNT_WIDTH_DEFAULT = 16;

  // Register values after reset.
  localparam logic                   SCAN_ENABLE_RESET = 1'b1;
  localparam logic [DELAY_WIDTH-1:0] SHORT_DELAY_RESET = 16'd3;
  localparam logic [DELAY_WIDTH-1:0] LONG_DELAY_RESET  = 16'd150;
  localparam logic [DELAY_WIDTH-1:0] CHORD_DELAY_RESET = 16'd50;

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    CFG_SCAN_ENABLE = 2'd0,
    CFG_SHORT_DELAY = 2'd1,
    CFG_LONG_DELAY  = 2'd2,
    CFG_CHORD_DELAY = 2'd3
  } cfg_reg_e;

  // Per-button event bits as they stand after a scan.
  typedef struct packed {
    logic debounced;
    logic pressed;
    logic released;
    logic short_ev;
    logic long_ev;
  } bde_flags_t;

  // Clear strobes carried by one request.
  typedef struct packed {
    logic chord;
    logic pressed;
    logic released;
    logic short_ev;
    logic long_ev;
  } bde_clear_t;

endpackage

// File: rtl/core/button_debounce_event_detector.sv
// Channel   Direction  Handshake                  Payload
// input     in         in_valid_i / in_stall_o    tick, pin_levels, five clear strobes
// output    out        out_valid_o / out_stall_i  seven 8-bit button bitmaps
// config    in         cfg_we_i                   cfg_index_i, cfg_data_i
//
// An accepted request lands in the input register and is evaluated once the output register
// is empty or draining, loading its result there. One request per cycle is sustained while
// the output is not stalled, set by the single evaluation stage between the two registers.
// Reset is asynchronous and active low; valid flags and detector state clear to zero, the
// configuration registers take their documented reset values; output bitmaps are not reset.
// A stalled output holds its result and a full input register its request, raising in_stall_o.
module button_debounce_event_detector #(
  parameter int BUTTONS     = bde_pkg::BUTTONS_DEFAULT,
  parameter int COUNT_WIDTH = bde_pkg::COUNT_WIDTH_DEFAULT
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Input channel.
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               tick_i,
  input  logic [bde_pkg::PIN_WIDTH-1:0]      pin_levels_i,
  input  logic                               clear_chord_i,
  input  logic                               clear_pressed_i,
  input  logic                               clear_released_i,
  input  logic                               clear_short_i,
  input  logic                               clear_long_i,
  // Output channel.
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [bde_pkg::PIN_WIDTH-1:0]      raw_buttons_o,
  output logic [bde_pkg::PIN_WIDTH-1:0]      debounced_buttons_o,
  output logic [bde_pkg::PIN_WIDTH-1:0]      chord_pattern_o,
  output logic [bde_pkg::PIN_WIDTH-1:0]      pressed_latch_o,
  output logic [bde_pkg::PIN_WIDTH-1:0]      released_latch_o,
  output logic [bde_pkg::PIN_WIDTH-1:0]      short_latch_o,
  output logic [bde_pkg::PIN_WIDTH-1:0]      long_latch_o,
  // Configuration write port.
  input  logic                               cfg_we_i,
  input  logic [bde_pkg::CFG_IDX_WIDTH-1:0]  cfg_index_i,
  input  logic [bde_pkg::DELAY_WIDTH-1:0]    cfg_data_i
);

  localparam int PW = bde_pkg::PIN_WIDTH;
  localparam int DW = bde_pkg::DELAY_WIDTH;
  // Pin bits at or above BUTTONS never reach the logic.
  localparam logic [PW-1:0] BtnMask = PW'((1 << BUTTONS) - 1);

  // Configuration registers.
  logic          scan_enable_q;
  logic [DW-1:0] short_delay_q, long_delay_q, chord_delay_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_enable_q <= bde_pkg::SCAN_ENABLE_RESET;
      short_delay_q <= bde_pkg::SHORT_DELAY_RESET;
      long_delay_q  <= bde_pkg::LONG_DELAY_RESET;
      chord_delay_q <= bde_pkg::CHORD_DELAY_RESET;
    end else if (cfg_we_i) begin
      case (bde_pkg::cfg_reg_e'(cfg_index_i))
        bde_pkg::CFG_SCAN_ENABLE: scan_enable_q <= cfg_data_i[0];
        bde_pkg::CFG_SHORT_DELAY: short_delay_q <= cfg_data_i;
        bde_pkg::CFG_LONG_DELAY:  long_delay_q  <= cfg_data_i;
        bde_pkg::CFG_CHORD_DELAY: chord_delay_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input register. It refills in the same cycle that its request is evaluated.
  logic                in_valid_q;
  logic                tick_q;
  logic [PW-1:0]       pins_q;
  bde_pkg::bde_clear_t clear_q;
  logic                fire;
  logic                scan;
  logic                in_take;

  // The evaluation stage fires when the output register is empty or draining.
  assign fire       = in_valid_q && (!out_valid_o || !out_stall_i);
  assign scan       = fire && tick_q && scan_enable_q;
  assign in_stall_o = in_valid_q && !fire;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      tick_q           <= tick_i;
      pins_q           <= pin_levels_i;
      clear_q.chord    <= clear_chord_i;
      clear_q.pressed  <= clear_pressed_i;
      clear_q.released <= clear_released_i;
      clear_q.short_ev <= clear_short_i;
      clear_q.long_ev  <= clear_long_i;
    end
  end

  // Active-low pins become a pressed pattern.
  logic [PW-1:0] pattern;
  assign pattern = ~pins_q & BtnMask;

  // The raw pattern follows the latest scan only.
  logic [PW-1:0] raw_q, raw_post;
  assign raw_post = scan ? pattern : raw_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_q <= '0;
    end else if (fire) begin
      raw_q <= raw_post;
    end
  end

  // One counter cell per button; unused bit positions read as zero.
  logic [PW-1:0] deb_post, prs_post, rel_post, shr_post, lng_post;

  for (genvar g = 0; g < PW; g++) begin : g_btn
    if (g < BUTTONS) begin : g_cell
      bde_pkg::bde_flags_t flags;

      bde_button #(
        .COUNT_WIDTH (COUNT_WIDTH)
      ) u_button (
        .clk_i         (clk_i),
        .rst_ni        (rst_ni),
        .fire_i        (fire),
        .scan_i        (scan),
        .held_i        (pattern[g]),
        .short_delay_i (short_delay_q),
        .long_delay_i  (long_delay_q),
        .clear_i       (clear_q),
        .flags_o       (flags)
      );

      assign deb_post[g] = flags.debounced;
      assign prs_post[g] = flags.pressed;
      assign rel_post[g] = flags.released;
      assign shr_post[g] = flags.short_ev;
      assign lng_post[g] = flags.long_ev;
    end else begin : g_none
      assign deb_post[g] = 1'b0;
      assign prs_post[g] = 1'b0;
      assign rel_post[g] = 1'b0;
      assign shr_post[g] = 1'b0;
      assign lng_post[g] = 1'b0;
    end
  end

  // Stable-pattern counter and chord latch.
  logic [PW-1:0] chord_post;

  bde_chord #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_chord (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fire_i        (fire),
    .scan_i        (scan),
    .pattern_i     (pattern),
    .chord_delay_i (chord_delay_q),
    .clear_i       (clear_q.chord),
    .chord_o       (chord_post)
  );

  // Output register. It reports every bitmap as it stands after the scan,
  // before this request's clears act.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (fire) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      raw_buttons_o       <= raw_post;
      debounced_buttons_o <= deb_post;
      chord_pattern_o     <= chord_post;
      pressed_latch_o     <= prs_post;
      released_latch_o    <= rel_post;
      short_latch_o       <= shr_post;
      long_latch_o        <= lng_post;
    end
  end

`ifndef ASSERT_OFF
  // A request blocked by a stalled result stays in the input register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && out_valid_o && out_stall_i) |=> in_valid_q)
    else $error("request lost while the output was stalled");

  // Buttons beyond BUTTONS never show up in a delivered result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (((raw_buttons_o | debounced_buttons_o | chord_pattern_o |
      pressed_latch_o | released_latch_o | short_latch_o | long_latch_o) & ~BtnMask) == '0))
    else $error("bitmap bit set for a button that does not exist");

  // A request without a scan leaves the raw pattern untouched.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && !scan) |=> $stable(raw_q))
    else $error("raw pattern changed without a scan");

  // A fired request always produces a result in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_o)
    else $error("evaluated request produced no result");
`endif

endmodule

// File: rtl/core/bde_button.sv
module bde_button #(
  parameter int COUNT_WIDTH = bde_pkg::COUNT_WIDTH_DEFAULT
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             fire_i,
  input  logic                             scan_i,
  input  logic                             held_i,
  input  logic [bde_pkg::DELAY_WIDTH-1:0]  short_delay_i,
  input  logic [bde_pkg::DELAY_WIDTH-1:0]  long_delay_i,
  input  bde_pkg::bde_clear_t              clear_i,
  output bde_pkg::bde_flags_t              flags_o
);

  localparam logic [COUNT_WIDTH-1:0] CntMax = '1;

  logic [COUNT_WIDTH-1:0]          count_q, count_d;
  bde_pkg::bde_flags_t             flags_q, flags_d, post;
  logic [COUNT_WIDTH-1:0]          count_inc;
  logic [bde_pkg::DELAY_WIDTH-1:0] inc_ext, cur_ext;

  assign count_inc = count_q + COUNT_WIDTH'(1);
  assign inc_ext   = bde_pkg::DELAY_WIDTH'(count_inc);
  assign cur_ext   = bde_pkg::DELAY_WIDTH'(count_q);

  // Scan of one button: count while held, flag press and long press, report on release.
  always_comb begin
    post    = flags_q;
    count_d = count_q;
    if (scan_i) begin
      if (held_i) begin
        if (count_q != CntMax) begin
          count_d = count_inc;
          if (inc_ext == short_delay_i) begin
            post.pressed   = 1'b1;
            post.debounced = 1'b1;
          end else if (inc_ext == long_delay_i) begin
            post.long_ev = 1'b1;
          end
        end
      end else begin
        if (cur_ext >= short_delay_i) begin
          post.released  = 1'b1;
          post.debounced = 1'b0;
          if (cur_ext < long_delay_i) begin
            post.short_ev = 1'b1;
          end
        end
        count_d = '0;
      end
    end
  end

  // Clears act after the result has been formed.
  always_comb begin
    flags_d          = post;
    flags_d.pressed  = post.pressed  & ~clear_i.pressed;
    flags_d.released = post.released & ~clear_i.released;
    flags_d.short_ev = post.short_ev & ~clear_i.short_ev;
    flags_d.long_ev  = post.long_ev  & ~clear_i.long_ev;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      flags_q <= '0;
    end else if (fire_i) begin
      count_q <= count_d;
      flags_q <= flags_d;
    end
  end

  assign flags_o = post;

endmodule

// File: rtl/core/bde_chord.sv
module bde_chord #(
  parameter int COUNT_WIDTH = bde_pkg::COUNT_WIDTH_DEFAULT
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             fire_i,
  input  logic                             scan_i,
  input  logic [bde_pkg::PIN_WIDTH-1:0]    pattern_i,
  input  logic [bde_pkg::DELAY_WIDTH-1:0]  chord_delay_i,
  input  logic                             clear_i,
  output logic [bde_pkg::PIN_WIDTH-1:0]    chord_o
);

  localparam logic [COUNT_WIDTH-1:0] CntMax = '1;

  logic [COUNT_WIDTH-1:0]         stable_q, stable_d;
  logic [bde_pkg::PIN_WIDTH-1:0]  prev_q, prev_d;
  logic [bde_pkg::PIN_WIDTH-1:0]  chord_q, post;

  always_comb begin
    stable_d = stable_q;
    prev_d   = prev_q;
    post     = chord_q;
    if (scan_i) begin
      if (pattern_i == prev_q) begin
        if (stable_q != CntMax) begin
          stable_d = stable_q + COUNT_WIDTH'(1);
        end
        if (bde_pkg::DELAY_WIDTH'(stable_d) == chord_delay_i) begin
          post = pattern_i;
        end
      end else begin
        stable_d = '0;
      end
      prev_d = pattern_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stable_q <= '0;
      prev_q   <= '0;
      chord_q  <= '0;
    end else if (fire_i) begin
      stable_q <= stable_d;
      prev_q   <= prev_d;
      chord_q  <= clear_i ? '0 : post;
    end
  end

  assign chord_o = post;

endmodule

// File: tb/tb_button_debounce_event_detector.sv
module tb_button_debounce_event_detector;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int                     PW          = bde_pkg::PIN_WIDTH;
  localparam int                     DW          = bde_pkg::DELAY_WIDTH;
  localparam logic [DW-1:0]          COUNT_MAX   = '1;
  // Cycles with no request and no result accepted before the run is declared hung.
  localparam int                     STUCK_LIMIT = 1000;

  localparam bde_pkg::bde_clear_t CLR_NONE     = '0;
  localparam bde_pkg::bde_clear_t CLR_CHORD    = '{chord: 1'b1, default: 1'b0};
  localparam bde_pkg::bde_clear_t CLR_PRESSED  = '{pressed: 1'b1, default: 1'b0};
  localparam bde_pkg::bde_clear_t CLR_RELEASED = '{released: 1'b1, default: 1'b0};
  localparam bde_pkg::bde_clear_t CLR_SHORT    = '{short_ev: 1'b1, default: 1'b0};
  localparam bde_pkg::bde_clear_t CLR_LONG     = '{long_ev: 1'b1, default: 1'b0};

  // One request as it will be driven onto the input channel.
  typedef struct packed {
    logic                tick;
    logic [PW-1:0]       pins;
    bde_pkg::bde_clear_t clr;
  } scan_req_t;

  // The seven bitmaps that one request reports.
  typedef struct packed {
    logic [PW-1:0] raw;
    logic [PW-1:0] debounced;
    logic [PW-1:0] chord;
    logic [PW-1:0] pressed;
    logic [PW-1:0] released;
    logic [PW-1:0] short_ev;
    logic [PW-1:0] long_ev;
  } button_report_t;

  // Every input of the block starts at a known value.
  logic              clk_i            = 1'b0;
  logic              rst_ni           = 1'b0;
  logic              in_valid_i       = 1'b0;
  logic              in_stall_o;
  logic              tick_i           = 1'b0;
  logic [PW-1:0]     pin_levels_i     = '1;
  logic              clear_chord_i    = 1'b0;
  logic              clear_pressed_i  = 1'b0;
  logic              clear_released_i = 1'b0;
  logic              clear_short_i    = 1'b0;
  logic              clear_long_i     = 1'b0;
  logic              out_valid_o;
  logic              out_stall_i      = 1'b0;
  logic [PW-1:0]     raw_buttons_o;
  logic [PW-1:0]     debounced_buttons_o;
  logic [PW-1:0]     chord_pattern_o;
  logic [PW-1:0]     pressed_latch_o;
  logic [PW-1:0]     released_latch_o;
  logic [PW-1:0]     short_latch_o;
  logic [PW-1:0]     long_latch_o;
  logic              cfg_we_i         = 1'b0;
  bde_pkg::cfg_reg_e cfg_index_i      = bde_pkg::CFG_SCAN_ENABLE;
  logic [DW-1:0]     cfg_data_i       = '0;

  button_debounce_event_detector u_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Requests waiting to be driven, and the reports that accepted requests owe.
  scan_req_t      scan_req_q[$];
  button_report_t expected_reports[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int mismatch_count = 0;
  int stuck_cycles   = 0;

  // Pin levels that the random sequences hold and perturb between requests.
  logic [PW-1:0] held_pins = '1;

  // Shadow of the configuration registers, at their reset values.
  logic          scan_en   = bde_pkg::SCAN_ENABLE_RESET;
  logic [DW-1:0] short_dly = bde_pkg::SHORT_DELAY_RESET;
  logic [DW-1:0] long_dly  = bde_pkg::LONG_DELAY_RESET;
  logic [DW-1:0] chord_dly = bde_pkg::CHORD_DELAY_RESET;

  // Shadow of the detector state, all zero after reset.
  logic [DW-1:0] hold_cnt[PW] = '{default: '0};
  logic [DW-1:0] stable_cnt   = '0;
  logic [PW-1:0] prev_pat     = '0;
  logic [PW-1:0] raw_pat      = '0;
  logic [PW-1:0] deb_bits     = '0;
  logic [PW-1:0] chord_bits   = '0;
  logic [PW-1:0] press_bits   = '0;
  logic [PW-1:0] rel_bits     = '0;
  logic [PW-1:0] short_bits   = '0;
  logic [PW-1:0] long_bits    = '0;

  // Advances the shadow state by one request and returns the report it produces.
  // The pins are active low, so a low pin is a held button. Clear strobes act
  // only after the report has been formed, which means a cleared latch is still
  // visible in the report of the request that clears it.
  function automatic button_report_t scan_buttons(input logic tick, input logic [PW-1:0] pins,
                                                  input bde_pkg::bde_clear_t clr);
    button_report_t rep;
    logic [PW-1:0]  pat;
    logic [DW-1:0]  cnt;
    if (tick && scan_en) begin
      pat     = ~pins;
      raw_pat = pat;
      // The chord latches once the pattern has been unchanged for chord_dly
      // ticks. A saturated counter that equals chord_dly latches on every tick.
      if (pat == prev_pat) begin
        if (stable_cnt != COUNT_MAX) stable_cnt++;
        if (stable_cnt == chord_dly) chord_bits = pat;
      end else begin
        stable_cnt = '0;
      end
      for (int b = 0; b < PW; b++) begin
        cnt = hold_cnt[b];
        if (pat[b]) begin
          // A held button counts up until it saturates. Reaching the short
          // delay takes precedence, so equal delays never flag a long press.
          if (cnt != COUNT_MAX) begin
            cnt++;
            if (cnt == short_dly) begin
              press_bits[b] = 1'b1;
              deb_bits[b]   = 1'b1;
            end else if (cnt == long_dly) begin
              long_bits[b] = 1'b1;
            end
          end
        end else begin
          // A release only counts once the press got past the short delay.
          if (cnt >= short_dly) begin
            rel_bits[b] = 1'b1;
            deb_bits[b] = 1'b0;
            if (cnt < long_dly) short_bits[b] = 1'b1;
          end
          cnt = '0;
        end
        hold_cnt[b] = cnt;
      end
      prev_pat = pat;
    end
    rep = '{raw: raw_pat, debounced: deb_bits, chord: chord_bits, pressed: press_bits,
            released: rel_bits, short_ev: short_bits, long_ev: long_bits};
    if (clr.chord)    chord_bits = '0;
    if (clr.pressed)  press_bits = '0;
    if (clr.released) rel_bits   = '0;
    if (clr.short_ev) short_bits = '0;
    if (clr.long_ev)  long_bits  = '0;
    return rep;
  endfunction

  function automatic void check_field(input string field, input logic [PW-1:0] want,
                                      input logic [PW-1:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%02h, actual 0x%02h", field, want, got);
      mismatch_count++;
    end
  endfunction

  // Request driver. A new request is only presented once the previous one has
  // been taken, so a stalled request keeps its payload. Whenever the slot is
  // free the sender may also choose to idle instead.
  always @(posedge clk_i) begin
    scan_req_t next_req;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        expected_reports.push_back(scan_buttons(tick_i, pin_levels_i,
            {clear_chord_i, clear_pressed_i, clear_released_i, clear_short_i, clear_long_i}));
      end
      if (!in_valid_i || !in_stall_o) begin
        if (scan_req_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_req = scan_req_q.pop_front();
          in_valid_i       <= 1'b1;
          tick_i           <= next_req.tick;
          pin_levels_i     <= next_req.pins;
          clear_chord_i    <= next_req.clr.chord;
          clear_pressed_i  <= next_req.clr.pressed;
          clear_released_i <= next_req.clr.released;
          clear_short_i    <= next_req.clr.short_ev;
          clear_long_i     <= next_req.clr.long_ev;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Report monitor. Each accepted report is matched against the oldest
  // expectation, field by field. The receiver stalls at random.
  always @(posedge clk_i) begin
    button_report_t want;
    if (rst_ni) begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
      if (out_valid_o && !out_stall_i) begin
        if (expected_reports.size() == 0) begin
          $error("report arrived with no request outstanding");
          mismatch_count++;
        end else begin
          want = expected_reports.pop_front();
          check_field("raw_buttons",       want.raw,       raw_buttons_o);
          check_field("debounced_buttons", want.debounced, debounced_buttons_o);
          check_field("chord_pattern",     want.chord,     chord_pattern_o);
          check_field("pressed_latch",     want.pressed,   pressed_latch_o);
          check_field("released_latch",    want.released,  released_latch_o);
          check_field("short_latch",       want.short_ev,  short_latch_o);
          check_field("long_latch",        want.long_ev,   long_latch_o);
        end
      end
    end
  end

  // Hang detection: the run ends if neither channel moves for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
      end
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("tb_button_debounce_event_detector failed");
        $finish;
      end
    end
  end

  // Waits until every queued request has been taken and every report has come
  // back, then lets the two-stage pipeline settle before anything else happens.
  task automatic drain();
    do @(negedge clk_i);
    while (scan_req_q.size() != 0 || in_valid_i || expected_reports.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input bde_pkg::cfg_reg_e idx, input logic [DW-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    case (idx)
      bde_pkg::CFG_SCAN_ENABLE: scan_en   = value[0];
      bde_pkg::CFG_SHORT_DELAY: short_dly = value;
      bde_pkg::CFG_LONG_DELAY:  long_dly  = value;
      bde_pkg::CFG_CHORD_DELAY: chord_dly = value;
      default: ;
    endcase
  endtask

  // Starts a new phase: the block is drained, all four registers are written
  // while it is idle, and the idling of both sides is set for what follows.
  task automatic start_phase(input logic en, input logic [DW-1:0] sd, input logic [DW-1:0] ld,
                             input logic [DW-1:0] cd, input int snd_pct, input int rcv_pct);
    drain();
    write_reg(bde_pkg::CFG_SCAN_ENABLE, {{(DW-1){1'b0}}, en});
    write_reg(bde_pkg::CFG_SHORT_DELAY, sd);
    write_reg(bde_pkg::CFG_LONG_DELAY, ld);
    write_reg(bde_pkg::CFG_CHORD_DELAY, cd);
    @(posedge clk_i);
    cfg_we_i       <= 1'b0;
    send_idle_pct  = snd_pct;
    recv_stall_pct = rcv_pct;
  endtask

  task automatic add_req(input logic tick, input logic [PW-1:0] pins,
                         input bde_pkg::bde_clear_t clr);
    scan_req_q.push_back('{tick: tick, pins: pins, clr: clr});
  endtask

  // Random requests built around held button patterns. Most requests keep the
  // pins as they were, so buttons stay down long enough to reach the delays;
  // some toggle one button and a few replace the whole pattern as bounce noise.
  // Ticks are dropped now and then and each clear strobe fires at random.
  task automatic queue_random(input int count, input int noise_pct, input int flip_pct);
    scan_req_t req;
    int        roll;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(99);
      if (roll < noise_pct) begin
        held_pins = PW'($urandom);
      end else if (roll < noise_pct + flip_pct) begin
        held_pins[$urandom_range(PW-1)] ^= 1'b1;
      end
      req.tick = ($urandom_range(9) != 0);
      req.pins = held_pins;
      for (int k = 0; k < $bits(bde_pkg::bde_clear_t); k++) begin
        req.clr[k] = ($urandom_range(5) == 0);
      end
      scan_req_q.push_back(req);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed requests with short delays so that every event shows up quickly.
    start_phase(1'b1, 16'd2, 16'd4, 16'd3, 15, 81);
    add_req(1'b1, 8'hFF, CLR_NONE);
    // All buttons held past both delays, long enough for the chord to latch.
    repeat (5) add_req(1'b1, 8'h00, CLR_NONE);
    // Without a tick the pins are ignored.
    add_req(1'b0, 8'h3C, CLR_NONE);
    // Releasing after a long press reports a release but no short press.
    add_req(1'b1, 8'hFF, CLR_NONE);
    // A press between the two delays ends as a short press.
    repeat (3) add_req(1'b1, 8'hFE, CLR_NONE);
    add_req(1'b1, 8'hFF, CLR_NONE);
    // A bounce shorter than the short delay leaves no event behind.
    add_req(1'b1, 8'h7F, CLR_NONE);
    add_req(1'b1, 8'hFF, CLR_CHORD);
    add_req(1'b1, 8'hFF, CLR_PRESSED);
    add_req(1'b1, 8'hFF, CLR_RELEASED);
    add_req(1'b1, 8'hFF, CLR_SHORT);
    add_req(1'b1, 8'hFF, CLR_LONG);
    add_req(1'b1, 8'hAA, CLR_NONE);
    add_req(1'b1, 8'h55, CLR_NONE);

    // Random phases, the sender mostly busy and the receiver mostly stalled.
    start_phase(1'b1, 16'd2, 16'd6, 16'd4, 15, 81);
    queue_random(140, 8, 12);
    // Equal short and long delays never flag a long press.
    start_phase(1'b1, 16'd3, 16'd3, 16'd1, 15, 81);
    queue_random(100, 8, 15);

    // The other way round: the sender idles most of the time.
    // Zero delays: every scanned button that is up reports a release, and the
    // chord never latches.
    start_phase(1'b1, 16'd0, 16'd5, 16'd0, 81, 15);
    queue_random(70, 10, 15);
    // Scanning disabled: ticks change nothing, but the clears still act.
    start_phase(1'b0, 16'd1, 16'd2, 16'd1, 81, 15);
    queue_random(40, 20, 20);

    // No idling on either side from here on.
    // The reset delays, with pins that change rarely so that long presses and
    // chords are reached.
    start_phase(1'b1, bde_pkg::SHORT_DELAY_RESET, bde_pkg::LONG_DELAY_RESET,
                bde_pkg::CHORD_DELAY_RESET, 0, 0);
    queue_random(280, 0, 1);

    // A short delay that is never reached and a long delay of one.
    start_phase(1'b1, COUNT_MAX, 16'd1, COUNT_MAX, 0, 0);
    queue_random(60, 10, 15);
    start_phase(1'b1, 16'd1, 16'd2, 16'd2, 0, 0);
    queue_random(90, 10, 20);

    drain();
    if (expected_reports.size() != 0) begin
      $error("%0d reports never arrived", expected_reports.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("tb_button_debounce_event_detector passed");
    end else begin
      $display("tb_button_debounce_event_detector failed");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/bde_pkg.sv
rtl/core/bde_button.sv
rtl/core/bde_chord.sv
rtl/core/button_debounce_event_detector.sv
tb/tb_button_debounce_event_detector.sv
